### rtl/dcbp_pkg.sv
// ----------------------------------------------------------------------------
// dcbp_pkg - shared types and constants of the coefficient box parser
// Record kinds, end status codes, the record group code passed from the
// front to the back, and the queue geometry.
// ----------------------------------------------------------------------------
package dcbp_pkg;

    // record kinds
    localparam logic [4:0] KIND_LOCATION      = 5'd0;
    localparam logic [4:0] KIND_FS_PRESENT    = 5'd1;
    localparam logic [4:0] KIND_FRAME_SIZE    = 5'd2;
    localparam logic [4:0] KIND_DELAY_MODE    = 5'd3;
    localparam logic [4:0] KIND_SEQ_COUNT     = 5'd4;
    localparam logic [4:0] KIND_PROFILE       = 5'd5;
    localparam logic [4:0] KIND_INTERP        = 5'd6;
    localparam logic [4:0] KIND_FULL_FRAME    = 5'd7;
    localparam logic [4:0] KIND_TIME_ALIGN    = 5'd8;
    localparam logic [4:0] KIND_TD_PRESENT    = 5'd9;
    localparam logic [4:0] KIND_TDELTA        = 5'd10;
    localparam logic [4:0] KIND_BAND_COUNT    = 5'd11;
    localparam logic [4:0] KIND_BAND_TYPE     = 5'd12;
    localparam logic [4:0] KIND_CHARACTERISTIC = 5'd13;
    localparam logic [4:0] KIND_CROSSOVER     = 5'd14;
    localparam logic [4:0] KIND_START_SUBBAND = 5'd15;
    localparam logic [4:0] KIND_END           = 5'd16;

    // end record status
    localparam logic [1:0] STATUS_COMPLETE  = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_TRAILING  = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // which set of field records a byte produces
    typedef enum logic [3:0] {
        GRP_NONE,
        GRP_HDR,
        GRP_FS,
        GRP_DELAY,
        GRP_SEQ,
        GRP_TD,
        GRP_BAND,
        GRP_CHAR,
        GRP_XOVER,
        GRP_SUB
    } grp_t;

    // one classified byte, waiting for expansion into records
    typedef struct packed {
        grp_t       grp;
        logic [7:0] data;
        logic [7:0] high;
        logic [5:0] seq;
        logic [3:0] band;
        logic       has_end;
        logic [1:0] end_status;
    } desc_t;

    // number of field records in a group, end record not counted
    function automatic logic [2:0] group_records(grp_t grp);
        logic [2:0] n;
        unique case (grp)
            GRP_HDR:   n = 3'd2;
            GRP_DELAY: n = 3'd2;
            GRP_BAND:  n = 3'd2;
            GRP_SEQ:   n = 3'd5;
            GRP_FS:    n = 3'd1;
            GRP_TD:    n = 3'd1;
            GRP_CHAR:  n = 3'd1;
            GRP_XOVER: n = 3'd1;
            GRP_SUB:   n = 3'd1;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

### rtl/dcbp_if.sv
// ----------------------------------------------------------------------------
// dcbp interfaces - byte and record channels
// Valid/ready channels carrying payload bytes in and decoded records out.
// ----------------------------------------------------------------------------
interface dcbp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       box_end;

    modport source (output valid, data_byte, box_end, input ready);
    modport sink   (input valid, data_byte, box_end, output ready);
endinterface

interface dcbp_rec_if;
    logic               valid;
    logic               ready;
    logic [4:0]         field_kind;
    logic signed [15:0] field_value;
    logic [5:0]         sequence_number;
    logic [3:0]         band_number;
    logic               reserved_warning;
    logic [1:0]         status;
    logic               last_of_run;

    modport source (output valid, field_kind, field_value, sequence_number, band_number,
                    reserved_warning, status, last_of_run, input ready);
    modport sink   (input valid, field_kind, field_value, sequence_number, band_number,
                    reserved_warning, status, last_of_run, output ready);
endinterface

### rtl/dcbp_front.sv
// ----------------------------------------------------------------------------
// dcbp_front - syntax tracker of the coefficient box parser
// Takes one payload byte per beat, walks the box syntax and pushes a
// descriptor of the records the byte produces into the queue.
// ----------------------------------------------------------------------------
module dcbp_front (
    input  logic              clk,
    input  logic              rst_n,
    dcbp_byte_if.sink         payload,
    input  logic              q_full,
    output logic              push,
    output dcbp_pkg::desc_t   desc
);

    typedef enum logic [3:0] {
        PH_HDR,
        PH_FS_HI,
        PH_FS_LO,
        PH_DELAY,
        PH_SEQ,
        PH_TD_HI,
        PH_TD_LO,
        PH_BAND,
        PH_CHAR,
        PH_XOVER,
        PH_SUB_HI,
        PH_SUB_LO,
        PH_DONE,
        PH_SKIP
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] high_reg, high_next;
    logic [5:0] seq_total_reg, seq_total_next;
    logic [5:0] seq_cnt_reg, seq_cnt_next;
    logic [3:0] band_total_reg, band_total_next;
    logic [3:0] band_cnt_reg, band_cnt_next;
    logic       band_type_reg, band_type_next;
    logic [1:0] profile_reg, profile_next;

    logic        accept;
    logic [7:0]  b;
    logic        done;
    logic        parsing;
    logic        go_seq;
    logic        go_idx;
    logic        end_rec;
    logic [1:0]  end_stat;
    logic [5:0]  seq_inc;
    logic [3:0]  band_inc;
    logic [5:0]  snap_seq;
    dcbp_pkg::grp_t grp;

    assign payload.ready = !q_full;
    assign accept        = payload.valid && payload.ready;
    assign b             = payload.data_byte;
    assign seq_inc       = seq_cnt_reg + 6'd1;
    assign band_inc      = band_cnt_reg + 4'd1;

    // next state of the syntax walk for the byte on the channel
    always_comb
    begin
        phase_next      = phase_reg;
        high_next       = high_reg;
        seq_total_next  = seq_total_reg;
        seq_cnt_next    = seq_cnt_reg;
        band_total_next = band_total_reg;
        band_cnt_next   = band_cnt_reg;
        band_type_next  = band_type_reg;
        profile_next    = profile_reg;
        done            = 1'b0;
        parsing         = 1'b1;
        go_seq          = 1'b0;
        go_idx          = 1'b0;
        end_rec         = 1'b0;
        end_stat        = dcbp_pkg::STATUS_COMPLETE;
        snap_seq        = seq_cnt_reg;
        grp             = dcbp_pkg::GRP_NONE;

        unique case (phase_reg)
            PH_HDR:
            begin
                seq_cnt_next  = '0;
                band_cnt_next = '0;
                snap_seq      = '0;
                grp           = dcbp_pkg::GRP_HDR;
                phase_next    = b[0] ? PH_FS_HI : PH_DELAY;
            end
            PH_FS_HI:
            begin
                high_next  = b;
                phase_next = PH_FS_LO;
            end
            PH_FS_LO:
            begin
                grp        = dcbp_pkg::GRP_FS;
                phase_next = PH_DELAY;
            end
            PH_DELAY:
            begin
                seq_total_next = b[5:0];
                seq_cnt_next   = '0;
                snap_seq       = '0;
                grp            = dcbp_pkg::GRP_DELAY;
                if (b[5:0] == 6'd0)
                    done = 1'b1;
                else
                    phase_next = PH_SEQ;
            end
            PH_SEQ:
            begin
                profile_next = b[5:4];
                grp          = dcbp_pkg::GRP_SEQ;
                if (b[0])
                    phase_next = PH_TD_HI;
                else if (b[5:4] != 2'd3)
                    phase_next = PH_BAND;
                else
                    go_seq = 1'b1;
            end
            PH_TD_HI:
            begin
                high_next  = b;
                phase_next = PH_TD_LO;
            end
            PH_TD_LO:
            begin
                grp = dcbp_pkg::GRP_TD;
                if (profile_reg != 2'd3)
                    phase_next = PH_BAND;
                else
                    go_seq = 1'b1;
            end
            PH_BAND:
            begin
                band_total_next = b[4:1];
                band_type_next  = b[0];
                band_cnt_next   = '0;
                grp             = dcbp_pkg::GRP_BAND;
                if (b[4:1] == 4'd0)
                    go_seq = 1'b1;
                else
                    phase_next = PH_CHAR;
            end
            PH_CHAR:
            begin
                grp           = dcbp_pkg::GRP_CHAR;
                band_cnt_next = band_inc;
                if (band_inc == 4'd0 || band_inc >= band_total_reg)
                begin
                    if (band_total_reg > 4'd1)
                    begin
                        band_cnt_next = 4'd1;
                        phase_next    = band_type_reg ? PH_XOVER : PH_SUB_HI;
                    end
                    else
                        go_seq = 1'b1;
                end
            end
            PH_XOVER:
            begin
                grp    = dcbp_pkg::GRP_XOVER;
                go_idx = 1'b1;
            end
            PH_SUB_HI:
            begin
                high_next  = b;
                phase_next = PH_SUB_LO;
            end
            PH_SUB_LO:
            begin
                grp    = dcbp_pkg::GRP_SUB;
                go_idx = 1'b1;
            end
            PH_DONE:
            begin
                parsing    = 1'b0;
                end_rec    = 1'b1;
                end_stat   = dcbp_pkg::STATUS_TRAILING;
                phase_next = payload.box_end ? PH_HDR : PH_SKIP;
            end
            default:
            begin
                parsing    = 1'b0;
                phase_next = payload.box_end ? PH_HDR : PH_SKIP;
            end
        endcase

        // step to the next band index
        if (go_idx)
        begin
            band_cnt_next = band_inc;
            if (band_inc == 4'd0 || band_inc >= band_total_reg)
                go_seq = 1'b1;
            else
                phase_next = band_type_reg ? PH_XOVER : PH_SUB_HI;
        end

        // step to the next sequence
        if (go_seq)
        begin
            seq_cnt_next  = seq_inc;
            band_cnt_next = '0;
            if (seq_inc == 6'd0 || seq_inc >= seq_total_reg)
                done = 1'b1;
            else
                phase_next = PH_SEQ;
        end

        // box end handling
        if (parsing)
        begin
            if (done)
            begin
                if (payload.box_end)
                begin
                    end_rec    = 1'b1;
                    end_stat   = dcbp_pkg::STATUS_COMPLETE;
                    phase_next = PH_HDR;
                end
                else
                    phase_next = PH_DONE;
            end
            else if (payload.box_end)
            begin
                end_rec    = 1'b1;
                end_stat   = dcbp_pkg::STATUS_TRUNCATED;
                phase_next = PH_HDR;
            end
        end
    end

    // descriptor towards the queue
    always_comb
    begin
        desc.grp        = grp;
        desc.data       = b;
        desc.high       = high_reg;
        desc.seq        = snap_seq;
        desc.band       = band_cnt_reg;
        desc.has_end    = end_rec;
        desc.end_status = end_stat;
    end

    assign push = accept && (grp != dcbp_pkg::GRP_NONE || end_rec);

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR;
            high_reg       <= '0;
            seq_total_reg  <= '0;
            seq_cnt_reg    <= '0;
            band_total_reg <= '0;
            band_cnt_reg   <= '0;
            band_type_reg  <= 1'b0;
            profile_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            high_reg       <= high_next;
            seq_total_reg  <= seq_total_next;
            seq_cnt_reg    <= seq_cnt_next;
            band_total_reg <= band_total_next;
            band_cnt_reg   <= band_cnt_next;
            band_type_reg  <= band_type_next;
            profile_reg    <= profile_next;
        end
    end

endmodule

### rtl/dcbp_queue.sv
// ----------------------------------------------------------------------------
// dcbp_queue - descriptor queue of the coefficient box parser
// Small first-in first-out store that decouples the syntax tracker from
// the record expansion.
// ----------------------------------------------------------------------------
module dcbp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dcbp_pkg::desc_t   push_desc,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output dcbp_pkg::desc_t   head
);

    localparam logic [dcbp_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        dcbp_pkg::QUEUE_PTR_W'(dcbp_pkg::QUEUE_DEPTH - 1);
    localparam logic [dcbp_pkg::QUEUE_PTR_W:0] DEPTH_CNT =
        (dcbp_pkg::QUEUE_PTR_W + 1)'(dcbp_pkg::QUEUE_DEPTH);

    dcbp_pkg::desc_t                  store [dcbp_pkg::QUEUE_DEPTH];
    logic [dcbp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [dcbp_pkg::QUEUE_PTR_W:0]   count_reg;
    logic                             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign valid   = (count_reg != '0);
    assign head    = store[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= push_desc;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/dcbp_back.sv
// ----------------------------------------------------------------------------
// dcbp_back - record expansion of the coefficient box parser
// Turns the descriptor at the head of the queue into its field records and
// any end record, one per cycle while the record sink is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module dcbp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  dcbp_pkg::desc_t   head,
    output logic              pop,
    dcbp_rec_if.source        records
);

    logic [2:0]         idx_reg;
    logic [2:0]         grp_cnt;
    logic [2:0]         total;
    logic               last;
    logic               load;
    logic               valid_reg;
    logic [4:0]         kind_reg;
    logic signed [15:0] value_reg;
    logic [5:0]         seq_reg;
    logic [3:0]         band_reg;
    logic               warn_reg;
    logic [1:0]         status_reg;
    logic               last_reg;

    logic [4:0]         kind;
    logic [15:0]        value;
    logic [5:0]         seq;
    logic [3:0]         band;
    logic               warn;
    logic [1:0]         stat;

    assign grp_cnt = dcbp_pkg::group_records(head.grp);
    assign total   = grp_cnt + {2'b00, head.has_end};
    assign last    = (idx_reg == total - 3'd1);
    assign load    = q_valid && (!valid_reg || records.ready);
    assign pop     = load && last;

    // record selected by the run index
    always_comb
    begin
        kind  = dcbp_pkg::KIND_END;
        value = '0;
        seq   = '0;
        band  = '0;
        warn  = 1'b0;
        stat  = head.end_status;
        if (idx_reg < grp_cnt)
        begin
            stat = dcbp_pkg::STATUS_COMPLETE;
            seq  = head.seq;
            unique case (head.grp)
                dcbp_pkg::GRP_HDR:
                begin
                    if (idx_reg == 3'd0)
                    begin
                        kind  = dcbp_pkg::KIND_LOCATION;
                        value = {{11{head.data[5]}}, head.data[5:1]};
                    end
                    else
                    begin
                        kind  = dcbp_pkg::KIND_FS_PRESENT;
                        value = {15'd0, head.data[0]};
                    end
                end
                dcbp_pkg::GRP_FS:
                begin
                    kind  = dcbp_pkg::KIND_FRAME_SIZE;
                    value = {1'b0, head.high[6:0], head.data};
                end
                dcbp_pkg::GRP_DELAY:
                begin
                    if (idx_reg == 3'd0)
                    begin
                        kind  = dcbp_pkg::KIND_DELAY_MODE;
                        value = {15'd0, head.data[6]};
                    end
                    else
                    begin
                        kind  = dcbp_pkg::KIND_SEQ_COUNT;
                        value = {10'd0, head.data[5:0]};
                    end
                end
                dcbp_pkg::GRP_SEQ:
                begin
                    unique case (idx_reg)
                        3'd0:
                        begin
                            kind  = dcbp_pkg::KIND_PROFILE;
                            value = {14'd0, head.data[5:4]};
                        end
                        3'd1:
                        begin
                            kind  = dcbp_pkg::KIND_INTERP;
                            value = {15'd0, head.data[3]};
                        end
                        3'd2:
                        begin
                            kind  = dcbp_pkg::KIND_FULL_FRAME;
                            value = {15'd0, head.data[2]};
                        end
                        3'd3:
                        begin
                            kind  = dcbp_pkg::KIND_TIME_ALIGN;
                            value = {15'd0, head.data[1]};
                        end
                        default:
                        begin
                            kind  = dcbp_pkg::KIND_TD_PRESENT;
                            value = {15'd0, head.data[0]};
                        end
                    endcase
                end
                dcbp_pkg::GRP_TD:
                begin
                    kind  = dcbp_pkg::KIND_TDELTA;
                    value = {5'd0, head.high[2:0], head.data};
                end
                dcbp_pkg::GRP_BAND:
                begin
                    if (idx_reg == 3'd0)
                    begin
                        kind  = dcbp_pkg::KIND_BAND_COUNT;
                        value = {12'd0, head.data[4:1]};
                    end
                    else
                    begin
                        kind  = dcbp_pkg::KIND_BAND_TYPE;
                        value = {15'd0, head.data[0]};
                    end
                end
                dcbp_pkg::GRP_CHAR:
                begin
                    kind  = dcbp_pkg::KIND_CHARACTERISTIC;
                    value = {9'd0, head.data[6:0]};
                    band  = head.band;
                    warn  = head.data[7];
                end
                dcbp_pkg::GRP_XOVER:
                begin
                    kind  = dcbp_pkg::KIND_CROSSOVER;
                    value = {12'd0, head.data[3:0]};
                    band  = head.band;
                end
                dcbp_pkg::GRP_SUB:
                begin
                    kind  = dcbp_pkg::KIND_START_SUBBAND;
                    value = {6'd0, head.high[1:0], head.data};
                    band  = head.band;
                end
                default:
                begin
                    kind = dcbp_pkg::KIND_END;
                end
            endcase
        end
    end

    // run index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg   <= last ? 3'd0 : idx_reg + 3'd1;
            valid_reg <= 1'b1;
        end
        else if (records.ready)
            valid_reg <= 1'b0;
    end

    // output record register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind;
            value_reg  <= signed'(value);
            seq_reg    <= seq;
            band_reg   <= band;
            warn_reg   <= warn;
            status_reg <= stat;
            last_reg   <= last;
        end
    end

    assign records.valid            = valid_reg;
    assign records.field_kind       = kind_reg;
    assign records.field_value      = value_reg;
    assign records.sequence_number  = seq_reg;
    assign records.band_number      = band_reg;
    assign records.reserved_warning = warn_reg;
    assign records.status           = status_reg;
    assign records.last_of_run      = last_reg;

endmodule

### rtl/drc_coefficient_box_parser_core.sv
// ----------------------------------------------------------------------------
// drc_coefficient_box_parser_core - coefficient box payload parser
// Byte-in, record-out parser for the payload of a dynamic range control
// coefficient box, after the common full-box header.
// ----------------------------------------------------------------------------
// The block takes one payload byte per beat and returns one tagged record
// per decoded field, closing each box with an end record. A byte is taken
// whenever the four-entry descriptor queue has room, so bytes may arrive
// back to back; the record side delivers one record per cycle while the
// sink is ready. A byte yields from no record (the high byte of a two-byte
// field that does not end the box, or a trailing byte after the first) up
// to six records (a sequence flags byte that also ends the box), so the
// sustained throughput is set by the record output register.
module drc_coefficient_box_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    dcbp_byte_if.sink   payload,
    dcbp_rec_if.source  records
);

    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    dcbp_pkg::desc_t  push_desc;
    dcbp_pkg::desc_t  head;

    // syntax tracker
    dcbp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (payload),
        .q_full  (q_full),
        .push    (push),
        .desc    (push_desc)
    );

    // descriptor queue
    dcbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (head)
    );

    // record expansion
    dcbp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .records (records)
    );

`ifndef SYNTHESIS
    // a nonzero status only on end records
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        records.valid && records.status != dcbp_pkg::STATUS_COMPLETE
        |-> records.field_kind == dcbp_pkg::KIND_END)
        else $error("status set on a field record");

    // an end record always closes its run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        records.valid && records.field_kind == dcbp_pkg::KIND_END
        |-> records.last_of_run)
        else $error("end record not last of run");

    // a run continues without a gap once a beat of it is taken
    a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        records.valid && records.ready && !records.last_of_run
        |=> records.valid)
        else $error("gap inside a record run");

    // the queue is never popped while empty
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("descriptor popped from empty queue");
`endif

endmodule
